@@ sv/chtab_pkg.sv @@
// Shared types, codes and constants of the chained hash table.
package chtab_pkg;

    localparam int KEY_W = 64;
    localparam int LEN_W = 4;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;
    localparam int CFG_W = 9;

    localparam logic [KEY_W-1:0] DJB2_START = 64'd5381;
    localparam int DJB2_SHIFT = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [ST_W-1:0] ST_NULL_VALUE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL       = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
    } t_req;

    // One stored entry as laid out in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

@@ sv/chtab_ifs.sv @@
// Channel interfaces of the chained hash table: request, response and configuration.
interface chtab_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] put_value;
    modport source (output valid, req_type, key_bytes, key_length, put_value, input ready);
    modport sink (input valid, req_type, key_bytes, key_length, put_value, output ready);
endinterface

interface chtab_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    modport source (output valid, status, read_value, input ready);
    modport sink (input valid, status, read_value, output ready);
endinterface

interface chtab_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] bucket_count;
    modport source (output valid, bucket_count, input ready);
    modport sink (input valid, bucket_count, output ready);
endinterface

@@ sv/chained_hash_table_core.sv @@
// Chained hash table: request beats on i_req, one response beat per request on o_rsp.
// Each request carries a get, put or delete, a key of up to eight bytes and a value.
// The bucket is the 64-bit djb2 hash of the key modulo the bucket_count register
// (0 taken as 1, capped at NUM_BUCKETS), which the user writes through i_cfg (always
// ready) only while no request is in flight; the block itself does not enforce this.
// The front end takes one request at a time: it hashes the key byte by byte, divides
// the hash bit-serially and pushes the item into the queue; the division sets the
// rate. The back end reads the bucket fill and scans the ways one by one, each with
// an issue and a compare step; a delete compacts the bucket with a read and a write
// per moved entry. A two-entry queue lets the front end hash the next key while the
// back end works. After reset the bucket fill memory is cleared bucket by bucket,
// during which i_req is not ready. The response is held in a register; while the
// receiver stalls, the back end waits and the queue fills, then i_req stalls.
module chained_hash_table_core #(
    parameter int NUM_BUCKETS   = 256,
    parameter int BUCKET_WAYS   = 4,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chtab_req_if.sink   i_req,
    chtab_rsp_if.source o_rsp,
    chtab_cfg_if.sink   i_cfg
);

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int Q_W   = $bits(chtab_pkg::t_req) + BKT_W;

    logic [8:0]       r_bucket_count;
    chtab_pkg::t_req  f_item;
    logic [BKT_W-1:0] f_bucket;
    logic             f_push;
    logic             q_full;
    logic             q_valid;
    logic [Q_W-1:0]   q_data;
    logic             b_pop;
    logic             b_clearing;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= chtab_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_bucket_count <= i_cfg.bucket_count;
        end
    end

    chtab_front #(
        .NUM_BUCKETS   (NUM_BUCKETS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .BKT_W         (BKT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_bucket_count (r_bucket_count),
        .i_hold         (b_clearing),
        .o_item         (f_item),
        .o_bucket       (f_bucket),
        .o_push         (f_push),
        .i_full         (q_full)
    );

    chtab_queue #(.WIDTH(Q_W), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_item, f_bucket}),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    chtab_back #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS),
        .BKT_W       (BKT_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_data[Q_W-1:BKT_W]),
        .i_bucket   (q_data[BKT_W-1:0]),
        .o_pop      (b_pop),
        .o_clearing (b_clearing),
        .o_rsp      (o_rsp)
    );

    // No request may enter while the fill memory is being cleared.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_clearing |-> !i_req.ready)
        else $error("request accepted during fill clear");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("queue overflow");

    // A pop only happens when the queue holds an item.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> q_valid)
        else $error("queue underflow");

endmodule

@@ sv/chtab_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module chtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/chtab_queue.sv @@
// Small FIFO that decouples the hashing front end from the table back end.
module chtab_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (!i_push && i_pop) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/chtab_front.sv @@
// Front end: accepts requests, masks the key, hashes it and reduces it to a bucket.
module chtab_front #(
    parameter int NUM_BUCKETS   = 256,
    parameter int MAX_KEY_BYTES = 8,
    parameter int BKT_W         = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    chtab_req_if.sink            i_req,
    input  logic [8:0]           i_bucket_count,
    input  logic                 i_hold,
    output chtab_pkg::t_req      o_item,
    output logic [BKT_W-1:0]     o_bucket,
    output logic                 o_push,
    input  logic                 i_full
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_DIV, F_PUSH} t_state;

    t_state          r_state;
    chtab_pkg::t_req r_item;
    logic [63:0]     r_hash;
    logic [3:0]      r_idx;
    logic [8:0]      r_div;
    logic [8:0]      r_rem;
    logic [5:0]      r_cnt;

    logic [3:0]  len_c;
    logic [63:0] key_m;
    logic [8:0]  div_c;
    logic [9:0]  trial;
    logic [8:0]  n_rem;
    logic [63:0] n_hash;

    always_comb begin
        len_c = (32'(i_req.key_length) > MAX_KEY_BYTES) ? 4'(MAX_KEY_BYTES)
                                                         : i_req.key_length;
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (b < 32'(len_c)) ? i_req.key_bytes[8*b +: 8] : 8'd0;
        end
        if (i_bucket_count == '0) begin
            div_c = 9'd1;
        end else if (32'(i_bucket_count) > NUM_BUCKETS) begin
            div_c = 9'(NUM_BUCKETS);
        end else begin
            div_c = i_bucket_count;
        end
        n_hash = (r_hash << chtab_pkg::DJB2_SHIFT) + r_hash
               + {56'd0, r_item.key[{r_idx[2:0], 3'b000} +: 8]};
        // Restoring division, one quotient bit per cycle.
        trial = {r_rem, r_hash[63]};
        n_rem = (trial >= {1'b0, r_div}) ? 9'(trial - {1'b0, r_div}) : trial[8:0];
    end

    assign i_req.ready = (r_state == F_IDLE) && !i_hold;
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_item      = r_item;
    assign o_bucket    = BKT_W'({23'd0, r_rem});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.valid && !i_hold) begin
                        r_item.req_type <= i_req.req_type;
                        r_item.key      <= key_m;
                        r_item.len      <= len_c;
                        r_item.value    <= i_req.put_value;
                        r_div           <= div_c;
                        r_hash          <= chtab_pkg::DJB2_START;
                        r_idx           <= '0;
                        r_state         <= F_HASH;
                    end
                end
                F_HASH: begin
                    if (r_idx == r_item.len) begin
                        r_rem   <= '0;
                        r_cnt   <= 6'd63;
                        r_state <= F_DIV;
                    end else begin
                        r_hash <= n_hash;
                        r_idx  <= 4'(r_idx + 1'b1);
                    end
                end
                F_DIV: begin
                    r_rem  <= n_rem;
                    r_hash <= {r_hash[62:0], 1'b0};
                    r_cnt  <= 6'(r_cnt - 1'b1);
                    if (r_cnt == '0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ sv/chtab_back.sv @@
// Back end: walks one bucket, applies get, put or delete and returns the response.
module chtab_back #(
    parameter int NUM_BUCKETS = 256,
    parameter int BUCKET_WAYS = 4,
    parameter int BKT_W       = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  chtab_pkg::t_req      i_item,
    input  logic [BKT_W-1:0]     i_bucket,
    output logic                 o_pop,
    output logic                 o_clearing,
    chtab_rsp_if.source          o_rsp
);

    localparam int SLOTS  = NUM_BUCKETS * BUCKET_WAYS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(BUCKET_WAYS + 1);
    localparam int ENT_W  = $bits(chtab_pkg::t_entry);

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_FILL, B_ISSUE, B_CMP, B_DECIDE, B_SH_RD, B_SH_WR
    } t_state;

    t_state           r_state;
    logic [BKT_W-1:0] r_clr;
    chtab_pkg::t_req  r_item;
    logic [BKT_W-1:0] r_bucket;
    logic [SLOT_W-1:0] r_base;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_way;
    logic [CNT_W-1:0] r_hit;
    logic             r_found;
    logic [31:0]      r_hit_val;
    logic             r_out_valid;
    logic [1:0]       r_status;
    logic [31:0]      r_rval;

    logic              fill_we;
    logic [BKT_W-1:0]  fill_waddr;
    logic [CNT_W-1:0]  fill_wdata;
    logic [BKT_W-1:0]  fill_raddr;
    logic [CNT_W-1:0]  fill_rdata;
    logic              ent_we;
    logic [SLOT_W-1:0] ent_waddr;
    chtab_pkg::t_entry ent_wdata;
    logic [SLOT_W-1:0] ent_raddr;
    chtab_pkg::t_entry ent_rdata;
    logic              hit_now;
    logic              shift_more;
    logic              del_shift;
    logic [1:0]        dec_status;
    logic [31:0]       dec_rval;
    logic              dec_shift;

    function automatic logic [SLOT_W-1:0] f_addr(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0] w);
        return SLOT_W'(base + SLOT_W'(w));
    endfunction

    chtab_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    chtab_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign o_pop       = (r_state == B_IDLE) && i_valid && !r_out_valid;
    assign o_clearing  = (r_state == B_CLEAR);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_rval;

    assign hit_now    = (ent_rdata.len == r_item.len) && (ent_rdata.key == r_item.key);
    assign del_shift  = ({1'b0, r_hit} + 1'b1) < {1'b0, r_fill};
    assign shift_more = ({1'b0, r_way} + 2'd2) < {1'b0, r_fill};
    assign dec_shift  = (r_item.req_type == chtab_pkg::REQ_DEL) && r_found && del_shift;

    always_comb begin
        dec_status = chtab_pkg::ST_NOT_FOUND;
        dec_rval   = '0;
        unique case (r_item.req_type)
            chtab_pkg::REQ_GET: begin
                if (r_found) begin
                    dec_status = chtab_pkg::ST_OK;
                    dec_rval   = r_hit_val;
                end
            end
            chtab_pkg::REQ_PUT: begin
                if (r_item.value == '0) begin
                    dec_status = chtab_pkg::ST_NULL_VALUE;
                end else if (r_found || 32'(r_fill) < BUCKET_WAYS) begin
                    dec_status = chtab_pkg::ST_OK;
                end else begin
                    dec_status = chtab_pkg::ST_FULL;
                end
            end
            chtab_pkg::REQ_DEL: begin
                if (r_found) begin
                    dec_status = chtab_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = r_bucket;
        fill_wdata = '0;
        fill_raddr = i_bucket;
        ent_we     = 1'b0;
        ent_waddr  = f_addr(r_base, r_way);
        ent_wdata  = {r_item.key, r_item.len, r_item.value};
        ent_raddr  = f_addr(r_base, r_way);
        case (r_state)
            B_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
            end
            B_SH_RD: begin
                ent_raddr = f_addr(r_base, CNT_W'(r_way + 1'b1));
            end
            B_SH_WR: begin
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                if (!shift_more) begin
                    fill_we    = 1'b1;
                    fill_wdata = CNT_W'(r_fill - 1'b1);
                end
            end
            B_DECIDE: begin
                if (r_item.req_type == chtab_pkg::REQ_PUT
                        && r_item.value != '0) begin
                    if (r_found) begin
                        ent_we    = 1'b1;
                        ent_waddr = f_addr(r_base, r_hit);
                    end else if (32'(r_fill) < BUCKET_WAYS) begin
                        ent_we     = 1'b1;
                        ent_waddr  = f_addr(r_base, r_fill);
                        fill_we    = 1'b1;
                        fill_wdata = CNT_W'(r_fill + 1'b1);
                    end
                end else if (r_item.req_type == chtab_pkg::REQ_DEL && r_found
                        && !del_shift) begin
                    fill_we    = 1'b1;
                    fill_wdata = CNT_W'(r_fill - 1'b1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= BKT_W'(r_clr + 1'b1);
                    if (32'(r_clr) == NUM_BUCKETS - 1) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (i_valid && !r_out_valid) begin
                        r_item   <= i_item;
                        r_bucket <= i_bucket;
                        r_base   <= SLOT_W'(32'(i_bucket) * BUCKET_WAYS);
                        r_state  <= B_FILL;
                    end
                end
                B_FILL: begin
                    r_fill  <= fill_rdata;
                    r_way   <= '0;
                    r_found <= 1'b0;
                    r_state <= B_ISSUE;
                end
                B_ISSUE: begin
                    r_state <= (r_way == r_fill) ? B_DECIDE : B_CMP;
                end
                B_CMP: begin
                    if (hit_now) begin
                        r_found   <= 1'b1;
                        r_hit     <= r_way;
                        r_hit_val <= ent_rdata.value;
                        r_state   <= B_DECIDE;
                    end else begin
                        r_way   <= CNT_W'(r_way + 1'b1);
                        r_state <= B_ISSUE;
                    end
                end
                B_DECIDE: begin
                    r_status <= dec_status;
                    r_rval   <= dec_rval;
                    if (dec_shift) begin
                        // Compaction runs first; the beat goes out at its end.
                        r_way   <= r_hit;
                        r_state <= B_SH_RD;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                B_SH_RD: begin
                    r_state <= B_SH_WR;
                end
                B_SH_WR: begin
                    if (shift_more) begin
                        r_way   <= CNT_W'(r_way + 1'b1);
                        r_state <= B_SH_RD;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the chained hash table: directed table, one-bucket test, then random traffic.
module tb_top;

    localparam int NB       = 256;
    localparam int WAYS     = 4;
    localparam int MAXK     = 8;
    localparam int CYC_LIMIT = 900000;
    localparam logic [chtab_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [chtab_pkg::ST_W-1:0]  status;
        logic [chtab_pkg::VAL_W-1:0] value;
    } t_rsp;

    typedef struct {
        logic [chtab_pkg::REQ_W-1:0] req;
        logic [chtab_pkg::KEY_W-1:0] key;
        logic [chtab_pkg::LEN_W-1:0] len;
        logic [chtab_pkg::VAL_W-1:0] val;
        bit                          typed;
        logic [chtab_pkg::ST_W-1:0]  st;
        logic [chtab_pkg::VAL_W-1:0] rv;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    chtab_req_if req_ch();
    chtab_rsp_if rsp_ch();
    chtab_cfg_if cfg_ch();

    chained_hash_table_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // Shadow copy of the table.
    int unsigned                 sh_div;
    int unsigned                 sh_fill [NB];
    logic [chtab_pkg::KEY_W-1:0] sh_key [NB*WAYS];
    logic [chtab_pkg::LEN_W-1:0] sh_len [NB*WAYS];
    logic [chtab_pkg::VAL_W-1:0] sh_val [NB*WAYS];

    t_rsp  pending_rsp [$];
    int    errors = 0;
    int    cycles = 0;
    int    send_idle = 0;
    int    recv_stall = 0;

    // Looks up and updates the shadow table exactly as the block does.
    function automatic t_rsp table_access(logic [chtab_pkg::REQ_W-1:0] req,
                                          logic [chtab_pkg::KEY_W-1:0] key_in,
                                          logic [chtab_pkg::LEN_W-1:0] len_in,
                                          logic [chtab_pkg::VAL_W-1:0] val);
        t_rsp                        r;
        int unsigned                 len;
        logic [chtab_pkg::KEY_W-1:0] key;
        logic [chtab_pkg::KEY_W-1:0] h;
        int unsigned                 div;
        int unsigned                 bkt;
        int unsigned                 base;
        int unsigned                 fill;
        int                          way;
        len = (32'(len_in) > MAXK) ? MAXK : 32'(len_in);
        key = (len >= 8) ? key_in : (key_in & ((64'd1 << (8 * len)) - 64'd1));
        h = chtab_pkg::DJB2_START;
        for (int i = 0; i < len; i++)
            h = (h << chtab_pkg::DJB2_SHIFT) + h + ((key >> (8 * i)) & 64'hFF);
        div = (sh_div == 0) ? 1 : ((sh_div > NB) ? NB : sh_div);
        bkt = int'(h % 64'(div));
        base = bkt * WAYS;
        fill = sh_fill[bkt];
        way = -1;
        for (int w = 0; w < fill; w++)
            if (way < 0 && 32'(sh_len[base+w]) == len && sh_key[base+w] == key) way = w;
        r.status = chtab_pkg::ST_NOT_FOUND;
        r.value = '0;
        case (req)
            chtab_pkg::REQ_GET: begin
                if (way >= 0) begin
                    r.status = chtab_pkg::ST_OK;
                    r.value = sh_val[base+way];
                end
            end
            chtab_pkg::REQ_PUT: begin
                if (val == '0) begin
                    r.status = chtab_pkg::ST_NULL_VALUE;
                end else if (way >= 0) begin
                    sh_val[base+way] = val;
                    r.status = chtab_pkg::ST_OK;
                end else if (fill >= WAYS) begin
                    r.status = chtab_pkg::ST_FULL;
                end else begin
                    sh_key[base+fill] = key;
                    sh_len[base+fill] = 4'(len);
                    sh_val[base+fill] = val;
                    sh_fill[bkt] = fill + 1;
                    r.status = chtab_pkg::ST_OK;
                end
            end
            chtab_pkg::REQ_DEL: begin
                if (way >= 0) begin
                    for (int w = way; w + 1 < fill; w++) begin
                        sh_key[base+w] = sh_key[base+w+1];
                        sh_len[base+w] = sh_len[base+w+1];
                        sh_val[base+w] = sh_val[base+w+1];
                    end
                    sh_fill[bkt] = fill - 1;
                    r.status = chtab_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Called at a falling edge; leaves valid high after the beat so that the next
    // request can follow at once.
    task automatic send_req(logic [chtab_pkg::REQ_W-1:0] req,
                            logic [chtab_pkg::KEY_W-1:0] key,
                            logic [chtab_pkg::LEN_W-1:0] len,
                            logic [chtab_pkg::VAL_W-1:0] val);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= req;
        req_ch.key_bytes <= key;
        req_ch.key_length <= len;
        req_ch.put_value <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_rsp.push_back(table_access(req, key, len, val));
        @(negedge i_clk);
    endtask

    task automatic send_typed(t_row row);
        t_rsp exp;
        send_req(row.req, row.key, row.len, row.val);
        if (row.typed) begin
            exp.status = row.st;
            exp.value = row.rv;
            pending_rsp[pending_rsp.size()-1] = exp;
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_buckets(logic [chtab_pkg::CFG_W-1:0] n);
        cfg_ch.valid <= 1'b1;
        cfg_ch.bucket_count <= n;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sh_div = 32'(n);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response checker and receiver stall.
    always @(posedge i_clk) begin
        t_rsp exp;
        cycles <= cycles + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response beat with no request outstanding");
                errors++;
            end else begin
                exp = pending_rsp.pop_front();
                if (rsp_ch.status !== exp.status) begin
                    $error("status: expected %0d, actual %0d", exp.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.read_value !== exp.value) begin
                    $error("read_value: expected %0h, actual %0h", exp.value,
                           rsp_ch.read_value);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk)
        rsp_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    always @(posedge i_clk)
        if (cycles >= CYC_LIMIT) begin
            $display("chained_hash_table_core test failed");
            $finish;
        end

    // Keys are mostly drawn from a small pool so gets and deletes find entries.
    logic [chtab_pkg::KEY_W-1:0] key_pool [16];
    logic [chtab_pkg::LEN_W-1:0] len_pool [16];

    task automatic random_phase(int count);
        int k;
        logic [chtab_pkg::REQ_W-1:0] rq;
        logic [chtab_pkg::KEY_W-1:0] key;
        logic [chtab_pkg::LEN_W-1:0] len;
        logic [chtab_pkg::VAL_W-1:0] val;
        for (int i = 0; i < count; i++) begin
            k = int'($urandom_range(15));
            key = key_pool[k];
            len = len_pool[k];
            if ($urandom_range(9) == 0) begin
                key = {$urandom, $urandom};
                len = 4'($urandom_range(15));
            end
            rq = ($urandom_range(9) < 4) ? chtab_pkg::REQ_PUT :
                 (($urandom_range(2) == 0) ? chtab_pkg::REQ_DEL :
                 (($urandom_range(19) == 0) ? REQ_UNKNOWN : chtab_pkg::REQ_GET));
            val = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
            send_req(rq, key, len, val);
        end
    endtask

    t_row dir_rows [$];

    function automatic t_row mk(logic [chtab_pkg::REQ_W-1:0] rq,
                                logic [chtab_pkg::KEY_W-1:0] key,
                                logic [chtab_pkg::LEN_W-1:0] len,
                                logic [chtab_pkg::VAL_W-1:0] val, bit typed,
                                logic [chtab_pkg::ST_W-1:0] st,
                                logic [chtab_pkg::VAL_W-1:0] rv);
        t_row r;
        r.req = rq; r.key = key; r.len = len; r.val = val;
        r.typed = typed; r.st = st; r.rv = rv;
        return r;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = chtab_pkg::REQ_GET;
        req_ch.key_bytes = '0;
        req_ch.key_length = '0;
        req_ch.put_value = '0;
        rsp_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.bucket_count = chtab_pkg::CFG_RESET;
        sh_div = 32'(chtab_pkg::CFG_RESET);
        foreach (sh_fill[i]) sh_fill[i] = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows.push_back(mk(chtab_pkg::REQ_GET, 64'h0, 4'd0, 32'd0, 1'b1,
                              chtab_pkg::ST_NOT_FOUND, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'h0, 4'd0, 32'hFFFF_FFFF, 1'b1,
                              chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_GET, 64'hFFFF, 4'd0, 32'd0, 1'b1,
                              chtab_pkg::ST_OK, 32'hFFFF_FFFF));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'h12, 4'd1, 32'd0, 1'b1,
                              chtab_pkg::ST_NULL_VALUE, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd1,
                              1'b1, chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0,
                              1'b1, chtab_pkg::ST_OK, 32'd1));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'hAAAA_5555_AAAA_5555, 4'd8,
                              32'h5555_AAAA, 1'b0, chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'hAAAA_5555_AAAA_5555, 4'd8,
                              32'hAAAA_5555, 1'b0, chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_GET, 64'hAAAA_5555_AAAA_5555, 4'd8, 32'd0,
                              1'b0, chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_PUT, 64'hFF00_0000_0000_0034, 4'd1, 32'd7,
                              1'b0, chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(REQ_UNKNOWN, 64'h0, 4'd0, 32'd9, 1'b1,
                              chtab_pkg::ST_NOT_FOUND, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_DEL, 64'h0, 4'd0, 32'd0, 1'b1,
                              chtab_pkg::ST_OK, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_DEL, 64'h0, 4'd0, 32'd0, 1'b1,
                              chtab_pkg::ST_NOT_FOUND, 32'd0));
        dir_rows.push_back(mk(chtab_pkg::REQ_GET, 64'h0, 4'd0, 32'd0, 1'b1,
                              chtab_pkg::ST_NOT_FOUND, 32'd0));
        foreach (dir_rows[i]) send_typed(dir_rows[i]);
        drain();

        // One bucket: fill it, overflow it, delete from the middle.
        write_buckets(9'd1);
        for (int i = 0; i < 6; i++)
            send_req(chtab_pkg::REQ_PUT, 64'h100 + 64'(i), 4'd2, 32'h10 + 32'(i));
        send_req(chtab_pkg::REQ_DEL, 64'h101, 4'd2, 32'd0);
        for (int i = 0; i < 6; i++)
            send_req(chtab_pkg::REQ_GET, 64'h100 + 64'(i), 4'd2, 32'd0);
        drain();

        foreach (key_pool[i]) begin
            key_pool[i] = {$urandom, $urandom};
            len_pool[i] = 4'($urandom_range(8));
        end
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_buckets(9'd0);
                1: write_buckets(9'd3);
                2: write_buckets(9'd511);
                3: write_buckets(9'd256);
                default: write_buckets(9'd7);
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            random_phase(105);
            drain();
        end

        if (errors == 0)
            $display("chained_hash_table_core test passed");
        else
            $display("chained_hash_table_core test failed");
        $finish;
    end
endmodule
